FILE: src/sha_pkg.sv
package sha_pkg;

  localparam int RoundCount = 64;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // control from the sequencer to the round core
  typedef struct packed {
    logic       start;   // load working vars from hash words
    logic       round;   // advance one round with w_in
    logic       fold;    // add working vars into hash words
    logic       reinit;  // restore initial hash words
  } core_ctl_t;

endpackage

FILE: src/sha_core.sv
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  core_ctl_t   ctl,
  input  logic [5:0]  round_idx,
  input  word_t       w_in,
  input  logic [2:0]  rd_idx,
  output word_t       rd_word
);

  word_t h_r [8];
  word_t v_r [8];
  word_t v_nxt [8];
  word_t big1, big0, choose, major, sum1;

  always_comb begin
    big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sum1   = v_r[7] + big1 + choose + round_k(round_idx) + w_in;
    big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    v_nxt[7] = v_r[6];
    v_nxt[6] = v_r[5];
    v_nxt[5] = v_r[4];
    v_nxt[4] = v_r[3] + sum1;
    v_nxt[3] = v_r[2];
    v_nxt[2] = v_r[1];
    v_nxt[1] = v_r[0];
    v_nxt[0] = sum1 + big0 + major;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (!rst_n || ctl.reinit) begin
        h_r[i] <= init_h(3'(i));
      end else if (ctl.fold) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
      if (ctl.start) begin
        v_r[i] <= h_r[i];
      end else if (ctl.round) begin
        v_r[i] <= v_nxt[i];
      end
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

FILE: src/sha256_byte_stream_hash.sv
// SHA-256 over a byte stream, one byte per beat.
// Bytes are absorbed while idle; the 64th byte of a block starts the message schedule,
// the round loop and a fold, and in_ready stays low until the block has been folded.
// Finish pads and compresses the closing block (a spilled second block too),
// then emits 8 digest beats, one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) restores the initial hash words and clears the counts.
module sha256_byte_stream_hash
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_SCHED, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t      state_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [63:0] total_r;
  logic        fin_r;      // finishing the message
  logic        two_r;      // padding spills into a second block
  logic        mark_r;     // 0x80 byte still to be placed in this pad pass
  logic [6:0]  cnt_r;      // pad/schedule/round counter
  logic [2:0]  widx_r;

  // block memory, one byte per entry
  logic [7:0]  blk_mem [64];
  logic        mem_we;
  logic [5:0]  mem_wa;
  logic [7:0]  mem_wd;
  logic [5:0]  mem_ra;
  logic [7:0]  mem_rd_r;

  // schedule memory, one word per round
  word_t       w_mem [64];
  logic        w_we;
  logic [5:0]  w_wa;
  word_t       w_wd;
  logic [5:0]  w_ra;
  word_t       w_rd_r;

  // 16-word window of the schedule for expansion
  word_t       win_r [16];
  word_t       byte_acc_r;
  word_t       s0, s1, new_w;

  core_ctl_t   ctl;
  word_t       h_word;

  sha_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .round_idx(cnt_r[5:0]),
    .w_in(w_rd_r), .rd_idx(widx_r), .rd_word(h_word)
  );

  always_ff @(posedge clk) begin
    if (mem_we) blk_mem[mem_wa] <= mem_wd;
    mem_rd_r <= blk_mem[mem_ra];
    if (w_we) w_mem[w_wa] <= w_wd;
    w_rd_r <= w_mem[w_ra];
  end

  // pad byte for position p of the closing block
  function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] f,
                                          input logic mark, input logic two,
                                          input logic [63:0] tot);
    logic [7:0] b;
    b = 8'h00;
    if (!two && p >= 6'd56) begin
      b = tot[8'(63 - 8 * (p - 6'd56)) -: 8];
    end
    if (mark && p == f) b = 8'h80;
    return b;
  endfunction

  always_comb begin
    s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    new_w = s1 + win_r[9] + s0 + win_r[0];
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    mem_we = 1'b0;
    mem_wa = fill_r;
    mem_wd = in_data_byte;
    mem_ra = cnt_r[5:0];
    w_we = 1'b0;
    w_wa = cnt_r[5:0] - 6'd1;
    w_wd = new_w;
    // fetch the next round's word ahead so word t is ready at round t
    w_ra = 6'd0;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        mem_we = in_valid && !in_command;
        mem_ra = 6'd0;
      end
      S_PAD: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[5:0];
        mem_wd = pad_byte(cnt_r[5:0], fill_r, mark_r, two_r, total_r);
        mem_ra = 6'd0;
      end
      S_SCHED: begin
        // at count c>=1 the read data holds byte c-1; words land every 4 bytes, expansion after
        mem_ra = cnt_r[5:0];
        if (cnt_r >= 7'd4 && cnt_r[1:0] == 2'd0 && cnt_r <= 7'd64) begin
          w_we = 1'b1;
          w_wa = 6'(cnt_r[6:2] - 5'd1);
          w_wd = {byte_acc_r[23:0], mem_rd_r};
        end else if (cnt_r > 7'd64) begin
          w_we = 1'b1;
          w_wa = 6'(cnt_r - 7'd49);
          w_wd = new_w;
        end
        ctl.start = (cnt_r == 7'd112);
      end
      S_ROUND: begin
        ctl.round = 1'b1;
        w_ra = cnt_r[5:0] + 6'd1;
      end
      S_FOLD:  ctl.fold = 1'b1;
      S_EMIT:  ctl.reinit = out_ready && (widx_r == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      mark_r <= 1'b0;
      cnt_r <= '0;
      widx_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_command) begin
              total_r <= bits_r + {55'd0, fill_r, 3'd0};
              two_r <= (fill_r >= 6'd56);
              mark_r <= 1'b1;
              fin_r <= 1'b1;
              cnt_r <= {1'b0, fill_r};
              state_r <= S_PAD;
            end else begin
              fill_r <= fill_r + 6'd1;
              if (fill_r == 6'd63) begin
                bits_r <= bits_r + 64'd512;
                cnt_r <= 7'd1;
                state_r <= S_SCHED;
              end
            end
          end
        end
        S_PAD: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_r <= 7'd1;
            state_r <= S_SCHED;
          end
        end
        S_SCHED: begin
          // read address runs with cnt; data arrives in the following cycle
          byte_acc_r <= {byte_acc_r[23:0], mem_rd_r};
          if (w_we) begin
            for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
            win_r[15] <= w_wd;
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd112) begin
            cnt_r <= 7'd0;
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (two_r) begin
            two_r <= 1'b0;
            mark_r <= 1'b0; // no marker in the second block
            cnt_r <= 7'd0;
            state_r <= S_PAD;
          end else begin
            widx_r <= 3'd0;
            out_valid <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) begin
              out_valid <= 1'b0;
              fin_r <= 1'b0;
              fill_r <= '0;
              bits_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_digest_word = h_word;
  assign out_word_index = widx_r;
  assign out_last_word = (widx_r == 3'd7);

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_valid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_EMIT)) else $error("result outside emit");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (state_r == S_IDLE))
    else $error("digest did not end");
`endif

endmodule
